// ===== sv/rnc_pkg.sv =====
// ----------------------------------------------------------------------------
// rnc_pkg
// Shared types and codes for the replay nonce cache: opcodes, result status
// codes and the control/status words that pass between the top and the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package rnc_pkg;

  localparam int unsigned HashW  = 64;
  localparam int unsigned StampW = 64;

  // Opcodes (bit 1 set means clear, so code three clears too)
  localparam logic [1:0] OP_CHECK = 2'd0;
  localparam logic [1:0] OP_EVICT = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_REFRESHED = 3'd1;
  localparam logic [2:0] ST_REPLAY    = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_EVICTED   = 3'd4;
  localparam logic [2:0] ST_CLEARED   = 3'd5;

  // Reset time to live: 300 s in microseconds
  localparam logic [63:0] TTL_RESET = 64'd300 * 64'd1000000;

  // Broadcast to every cell
  typedef struct packed {
    logic              check;      // apply a check item this cycle
    logic              evict;      // drop expired entries this cycle
    logic              clear;      // empty the table this cycle
    logic              any_match;  // some cell holds the hash
    logic [HashW-1:0]  hash;
    logic [StampW-1:0] stamp;
    logic [StampW-1:0] ttl;
  } cell_cmd_t;

  // Returned by every cell
  typedef struct packed {
    logic valid;
    logic match;
    logic expired;
  } cell_stat_t;

endpackage

`default_nettype wire

// ===== sv/rnc_cell.sv =====
// ----------------------------------------------------------------------------
// rnc_cell
// One table entry: valid flag, hash and last-accepted time. Compares and
// ages itself against the broadcast word; a free-slot flag ripples along
// the row so that only the lowest free cell takes a new hash.
// ----------------------------------------------------------------------------
`default_nettype none

module rnc_cell
  import rnc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cell_cmd_t  cmd_i,
  input  wire logic       free_below_i,
  output logic            free_below_o,
  output cell_stat_t      stat_o
);

  logic              valid_q, valid_d;
  logic [HashW-1:0]  hash_q;
  logic [StampW-1:0] time_q;
  logic [StampW-1:0] age;
  logic              expired;
  logic              match;
  logic              take;
  logic              refresh;

  assign age     = cmd_i.stamp - time_q;   // modulo 2^64
  assign expired = (age >= cmd_i.ttl);
  assign match   = valid_q && (hash_q == cmd_i.hash);

  // lowest free cell takes an unknown hash
  assign take         = cmd_i.check && !cmd_i.any_match && !valid_q && !free_below_i;
  assign refresh      = cmd_i.check && match && expired;
  assign free_below_o = free_below_i | ~valid_q;

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.clear) begin
      valid_d = 1'b0;
    end else if (cmd_i.evict && valid_q && expired) begin
      valid_d = 1'b0;
    end else if (take) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      hash_q <= cmd_i.hash;
    end
    if (take || refresh) begin
      time_q <= cmd_i.stamp;
    end
  end

  assign stat_o.valid   = valid_q;
  assign stat_o.match   = match;
  assign stat_o.expired = expired;

endmodule

`default_nettype wire

// ===== sv/rnc_popcount.sv =====
// ----------------------------------------------------------------------------
// rnc_popcount
// Counts valid cells through a registered two-level tree: groups of eight
// are counted and registered, the group counts are summed behind them.
// ----------------------------------------------------------------------------
`default_nettype none

module rnc_popcount #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                         clk_i,
  input  wire logic [DEPTH-1:0]             valid_i,
  output logic [$clog2(DEPTH+1)-1:0]        count_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned NG = (DEPTH + 7) / 8;
  localparam int unsigned PW = NG * 8;

  logic [PW-1:0] padded;
  logic [3:0]    groups_d [NG];
  logic [3:0]    groups_q [NG];

  assign padded = PW'(valid_i);

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      groups_d[g] = 4'd0;
      for (int b = 0; b < 8; b++) begin
        groups_d[g] = groups_d[g] + 4'(padded[g*8+b]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    groups_q <= groups_d;
  end

  always_comb begin
    count_o = '0;
    for (int g = 0; g < NG; g++) begin
      count_o = count_o + CW'(groups_q[g]);
    end
  end

endmodule

`default_nettype wire

// ===== sv/replay_nonce_cache_ttl_top.sv =====
// ----------------------------------------------------------------------------
// replay_nonce_cache_ttl_top
// Anti-replay nonce cache with time to live, built as a row of entry cells.
//
//   channel   direction  handshake             payload
//   command   in         start / busy          opcode_i, hash_i, timestamp_i
//   result    out        done_o (one cycle)    accepted_o, status_o, entry_count_o
//   ttl       in         cfg_we_i              cfg_wdata_i (64-bit TTL, us)
//
// A command word is taken at a clock edge with start high and busy low.
// Check and clear: the word is captured, then all cells compare hash and
// age in parallel and update in the compare state. Evict goes on: after
// the update the valid count is rebuilt by a two-stage popcount tree.
// The result shows on done_o for one cycle right after the last busy cycle;
// the receiver cannot stall, and a new word may be taken in that same cycle.
// Reset clears all valid flags and the count at once; no clearing pass.
// Hash and time storage is left unreset and only read behind a valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module replay_nonce_cache_ttl_top
  import rnc_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // command
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        opcode_i,
  input  wire logic [HashW-1:0]  hash_i,
  input  wire logic [StampW-1:0] timestamp_i,
  // TTL register
  input  wire logic              cfg_we_i,
  input  wire logic [63:0]       cfg_wdata_i,
  // result
  output logic                   done_o,
  output logic                   accepted_o,
  output logic [2:0]             status_o,
  output logic [6:0]             entry_count_o
);

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;  // compare and update all cells
  localparam logic [1:0] S_CNT  = 2'd2;  // evict: group counts register
  localparam logic [1:0] S_SUM  = 2'd3;  // evict: final sum

  logic [1:0]        state_q, state_d;
  logic [1:0]        op_q;
  logic [HashW-1:0]  hash_q;
  logic [StampW-1:0] stamp_q;
  logic [63:0]       ttl_q;
  logic [CW-1:0]     count_q, count_d;

  logic              done_q, done_d;
  logic              acc_q, acc_d;
  logic [2:0]        status_q, status_d;

  cell_cmd_t         cmd;
  cell_stat_t        stat [TABLE_DEPTH];
  logic [TABLE_DEPTH:0]   free_chain;
  logic [TABLE_DEPTH-1:0] valid_vec, match_vec, fresh_vec;
  logic              any_match, any_free, fresh_hit;
  logic [CW-1:0]     pop_count;
  logic [CW+6:0]     count_ext;
  logic              accept;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  // command capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= opcode_i;
      hash_q  <= hash_i;
      stamp_q <= timestamp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q <= TTL_RESET;
    end else if (cfg_we_i) begin
      ttl_q <= cfg_wdata_i;
    end
  end

  // broadcast word, live only in the compare cycle
  always_comb begin
    cmd.check     = (state_q == S_CMP) && (op_q == OP_CHECK);
    cmd.evict     = (state_q == S_CMP) && (op_q == OP_EVICT);
    cmd.clear     = (state_q == S_CMP) && (op_q == OP_CLEAR || op_q == OP_SPARE);
    cmd.any_match = any_match;
    cmd.hash      = hash_q;
    cmd.stamp     = stamp_q;
    cmd.ttl       = ttl_q;
  end

  // row of entry cells; free flag ripples from cell 0 upward
  assign free_chain[0] = 1'b0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    rnc_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .free_below_i (free_chain[i]),
      .free_below_o (free_chain[i+1]),
      .stat_o       (stat[i])
    );
    assign valid_vec[i] = stat[i].valid;
    assign match_vec[i] = stat[i].match;
    assign fresh_vec[i] = stat[i].match && !stat[i].expired;
  end

  assign any_match = |match_vec;
  assign fresh_hit = |fresh_vec;
  assign any_free  = free_chain[TABLE_DEPTH];

  rnc_popcount #(
    .DEPTH (TABLE_DEPTH)
  ) u_popcount (
    .clk_i   (clk_i),
    .valid_i (valid_vec),
    .count_o (pop_count)
  );

  // sequencer and result formation
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    done_d   = 1'b0;
    acc_d    = 1'b0;
    status_d = status_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (op_q[1]) begin
          count_d  = '0;
          status_d = ST_CLEARED;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else if (op_q == OP_EVICT) begin
          state_d = S_CNT;
        end else begin
          done_d  = 1'b1;
          state_d = S_IDLE;
          if (any_match) begin
            acc_d    = !fresh_hit;
            status_d = fresh_hit ? ST_REPLAY : ST_REFRESHED;
          end else if (any_free) begin
            acc_d    = 1'b1;
            status_d = ST_INSERTED;
            count_d  = count_q + CW'(1);
          end else begin
            status_d = ST_FULL;
          end
        end
      end
      S_CNT: begin
        state_d = S_SUM;
      end
      S_SUM: begin
        count_d  = pop_count;
        status_d = ST_EVICTED;
        done_d   = 1'b1;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    status_q <= status_d;
  end

  assign count_ext     = {7'd0, count_q};
  assign done_o        = done_q;
  assign accepted_o    = acc_q;
  assign status_o      = status_q;
  assign entry_count_o = count_ext[6:0];

`ifndef ASSERT_OFF
  // a hash lives in at most one cell
  a_match_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match_vec))
    else $error("hash held by more than one cell");

  // count never exceeds the table
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH))
    else $error("entry count out of range");

  // a result follows a busy cycle
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without work");

  // only insert and refresh accept
  a_accept_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && accepted_o) |-> (status_o == ST_INSERTED || status_o == ST_REFRESHED))
    else $error("accepted with wrong status");

  // taking a word always starts work
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("word taken but not busy");
`endif

endmodule

`default_nettype wire
